/* rtl/core/box_blur_rgb_resample_unit_macros.svh */
// Assertion macros for the box blur resampler.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BOX_BLUR_RGB_RESAMPLE_UNIT_MACROS_SVH
`define BOX_BLUR_RGB_RESAMPLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define BBRR_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) \
    else $error("bbrr: assertion failed");
`define BBRR_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("bbrr: assertion failed");
`else
`define BBRR_ASSERT(lbl, ck, rs, prop)
`define BBRR_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif

`endif

/* rtl/core/bbrr_pkg.sv */
// Shared types, codes and constants for the box blur resampler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bbrr_pkg;

  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 128;

  // configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_IN_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IN_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INV_SCALE = 2'd2;

  localparam logic [7:0]  RST_IN_WIDTH  = 8'd128;
  localparam logic [7:0]  RST_IN_HEIGHT = 8'd128;
  localparam logic [15:0] RST_INV_SCALE = 16'd512;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  typedef struct packed {
    logic [7:0]  in_width;
    logic [7:0]  in_height;
    logic [15:0] inv_scale_q8;
  } cfg_t;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
  } mul_req_t;

  // floor((2^16 - 1) / n): quotient from the product is low by at most one
  function automatic logic [15:0] recip(input logic [3:0] n);
    logic [15:0] r;
    case (n)
      4'd1:    r = 16'd65535;
      4'd2:    r = 16'd32767;
      4'd3:    r = 16'd21845;
      4'd4:    r = 16'd16383;
      4'd5:    r = 16'd13107;
      4'd6:    r = 16'd10922;
      4'd7:    r = 16'd9362;
      4'd8:    r = 16'd8191;
      4'd9:    r = 16'd7281;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bbrr_ram.sv */
// Image store: one write port, one read port, registered read data.
// Depends on nothing; depth and address width come from the parent.
`timescale 1ns / 1ps
`default_nettype none

module bbrr_ram #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [23:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [23:0]   rdata
);

  logic [23:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/bbrr_mul.sv */
// Shared 16x16 multiplier with registered product.
// Depends on bbrr_pkg for the request type.
`timescale 1ns / 1ps
`default_nettype none

module bbrr_mul (
  input  wire logic              clk,
  input  wire bbrr_pkg::mul_req_t req,
  output logic [31:0]            prod
);

  always_ff @(posedge clk) begin
    prod <= {16'd0, req.a} * {16'd0, req.b};
  end

endmodule

`default_nettype wire

/* rtl/core/bbrr_ctrl.sv */
// Sequencer: coordinate scaling and reciprocal divide through the shared
// multiplier, and the window walk over the store. Uses bbrr_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "box_blur_rgb_resample_unit_macros.svh"

module bbrr_ctrl #(
  parameter int MAX_WIDTH  = bbrr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbrr_pkg::DEF_MAX_HEIGHT,
  parameter int AW         = 14
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               action,
  input  wire logic [9:0]         col,
  input  wire logic [9:0]         row,
  input  wire logic [7:0]         red_in,
  input  wire logic [7:0]         green_in,
  input  wire logic [7:0]         blue_in,
  input  wire bbrr_pkg::cfg_t     cfg,
  output bbrr_pkg::mul_req_t      mul_req,
  input  wire logic [31:0]        mul_prod,
  output logic                    ram_we,
  output logic [AW-1:0]           ram_waddr,
  output logic [23:0]             ram_wdata,
  output logic [AW-1:0]           ram_raddr,
  input  wire logic [23:0]        ram_rdata,
  output logic                    done,
  output logic [7:0]              red_out,
  output logic [7:0]              green_out,
  output logic [7:0]              blue_out,
  output logic [3:0]              sample_count,
  output logic                    window_empty
);

  localparam int CMAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CW   = $clog2(CMAX + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MULY, S_WIN, S_READ, S_ACC, S_DR, S_DG, S_DB, S_FIN
  } state_t;

  state_t        state;
  logic [9:0]    row_q;
  logic [CW-1:0] x0, x1, y1, x, y;
  logic          empty_x;
  logic [3:0]    cnt;
  logic [11:0]   sum_r, sum_g, sum_b;
  logic          pend;

  logic          accept;
  logic [17:0]   center;
  logic [17:0]   lo_full;
  logic [18:0]   hi_full, lim, lim_x, lim_y, hi_clip;
  logic          ax_empty;
  logic [11:0]   div_sum;
  logic [7:0]    quot;

  function automatic logic [7:0] fix_quot(input logic [31:0] prod, input logic [11:0] sum,
                                          input logic [3:0] n);
    logic [7:0]  q;
    logic [11:0] qn;
    logic [11:0] rem;
    q   = prod[23:16];
    qn  = {4'd0, q} * {8'd0, n};
    rem = sum - qn;
    return (rem >= {8'd0, n}) ? q + 8'd1 : q;
  endfunction

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // load path writes straight into the store
  assign ram_we    = accept && (action == bbrr_pkg::ACT_LOAD) &&
                     (32'(col) < MAX_WIDTH) && (32'(row) < MAX_HEIGHT);
  assign ram_waddr = AW'(row) * AW'(MAX_WIDTH) + AW'(col);
  assign ram_wdata = {red_in, green_in, blue_in};
  assign ram_raddr = AW'(y) * AW'(MAX_WIDTH) + AW'(x);

  // window bounds for whichever axis the product belongs to
  assign lim_x = (32'(cfg.in_width) > MAX_WIDTH) ? 19'(MAX_WIDTH) : 19'(cfg.in_width);
  assign lim_y = (32'(cfg.in_height) > MAX_HEIGHT) ? 19'(MAX_HEIGHT) : 19'(cfg.in_height);
  assign lim      = (state == S_MULY) ? lim_x : lim_y;
  assign center   = mul_prod[25:8];
  assign lo_full  = (center != 18'd0) ? center - 18'd1 : 18'd0;
  assign hi_full  = {1'b0, center} + 19'd2;
  assign hi_clip  = (hi_full > lim) ? lim : hi_full;
  assign ax_empty = ({1'b0, lo_full} >= hi_clip);

  always_comb begin
    case (state)
      S_DG:    div_sum = sum_r;
      S_DB:    div_sum = sum_g;
      default: div_sum = sum_b;
    endcase
  end
  assign quot = fix_quot(mul_prod, div_sum, cnt);

  always_comb begin
    mul_req = '0;
    case (state)
      S_IDLE: begin
        mul_req.a = {6'd0, col};
        mul_req.b = cfg.inv_scale_q8;
      end
      S_MULY: begin
        mul_req.a = {6'd0, row_q};
        mul_req.b = cfg.inv_scale_q8;
      end
      S_DR: begin
        mul_req.a = {4'd0, sum_r};
        mul_req.b = bbrr_pkg::recip(cnt);
      end
      S_DG: begin
        mul_req.a = {4'd0, sum_g};
        mul_req.b = bbrr_pkg::recip(cnt);
      end
      S_DB: begin
        mul_req.a = {4'd0, sum_b};
        mul_req.b = bbrr_pkg::recip(cnt);
      end
      default: mul_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      pend         <= 1'b0;
      cnt          <= 4'd0;
      window_empty <= 1'b0;
      sample_count <= 4'd0;
    end else begin
      done <= 1'b0;
      pend <= (state == S_READ);
      if (pend) begin
        sum_r <= sum_r + {4'd0, ram_rdata[23:16]};
        sum_g <= sum_g + {4'd0, ram_rdata[15:8]};
        sum_b <= sum_b + {4'd0, ram_rdata[7:0]};
      end
      case (state)
        S_IDLE: begin
          if (accept && action == bbrr_pkg::ACT_COMPUTE) begin
            row_q <= row;
            state <= S_MULY;
          end
        end
        S_MULY: begin
          x0      <= CW'(lo_full);
          x1      <= CW'(hi_clip);
          empty_x <= ax_empty;
          state   <= S_WIN;
        end
        S_WIN: begin
          if (empty_x || ax_empty) begin
            red_out      <= 8'd0;
            green_out    <= 8'd0;
            blue_out     <= 8'd0;
            sample_count <= 4'd0;
            window_empty <= 1'b1;
            done         <= 1'b1;
            state        <= S_IDLE;
          end else begin
            y1    <= CW'(hi_clip);
            y     <= CW'(lo_full);
            x     <= x0;
            sum_r <= 12'd0;
            sum_g <= 12'd0;
            sum_b <= 12'd0;
            cnt   <= 4'd0;
            state <= S_READ;
          end
        end
        S_READ: begin
          cnt <= cnt + 4'd1;
          if (x + CW'(1) == x1) begin
            x <= x0;
            if (y + CW'(1) == y1) begin
              state <= S_ACC;
            end else begin
              y <= y + CW'(1);
            end
          end else begin
            x <= x + CW'(1);
          end
        end
        S_ACC: state <= S_DR;
        S_DR:  state <= S_DG;
        S_DG: begin
          red_out <= quot;
          state   <= S_DB;
        end
        S_DB: begin
          green_out <= quot;
          state     <= S_FIN;
        end
        S_FIN: begin
          blue_out     <= quot;
          sample_count <= cnt;
          window_empty <= 1'b0;
          done         <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BBRR_ASSERT(a_done_idle, clk, rst, !done || state == S_IDLE)
  `BBRR_ASSERT(a_empty_zero, clk, rst, !(done && window_empty) || (red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0 && sample_count == 4'd0))
  `BBRR_ASSERT(a_count_range, clk, rst, !(done && !window_empty) || (sample_count != 4'd0 && sample_count <= 4'd9))
  `BBRR_ASSERT(a_cnt_max, clk, rst, cnt <= 4'd9)
  `BBRR_ASSERT_NEXT(a_compute_busy, clk, rst, start && !busy && action == bbrr_pkg::ACT_COMPUTE, busy)

endmodule

`default_nettype wire

/* rtl/core/box_blur_rgb_resample_unit.sv */
// Load: no result; start may be taken again the next cycle.
// Compute: x and y scaling, a serial walk over the N window pixels (1..9, one
// read per cycle), then the red, green and blue divides before done; an empty
// window ends after y scaling. Scaling and divides share the multiplier; start is taken again once busy drops.
// rst (sync, high) resets the sequencer and sets the config to its defaults; the store is not cleared.
// done is high for one cycle with the result; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module box_blur_rgb_resample_unit #(
  parameter int MAX_WIDTH  = bbrr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbrr_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          action,
  input  wire logic [9:0]                    col,
  input  wire logic [9:0]                    row,
  input  wire logic [7:0]                    red_in,
  input  wire logic [7:0]                    green_in,
  input  wire logic [7:0]                    blue_in,
  output logic                               done,
  output logic [7:0]                         red_out,
  output logic [7:0]                         green_out,
  output logic [7:0]                         blue_out,
  output logic [3:0]                         sample_count,
  output logic                               window_empty,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bbrr_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  bbrr_pkg::cfg_t     cfg;
  bbrr_pkg::mul_req_t mul_req;
  logic [31:0]        mul_prod;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [23:0]        ram_wdata;
  logic [23:0]        ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.in_width     <= bbrr_pkg::RST_IN_WIDTH;
      cfg.in_height    <= bbrr_pkg::RST_IN_HEIGHT;
      cfg.inv_scale_q8 <= bbrr_pkg::RST_INV_SCALE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bbrr_pkg::REG_IN_WIDTH:  cfg.in_width     <= cfg_data[7:0];
        bbrr_pkg::REG_IN_HEIGHT: cfg.in_height    <= cfg_data[7:0];
        bbrr_pkg::REG_INV_SCALE: cfg.inv_scale_q8 <= cfg_data;
        default: ;
      endcase
    end
  end

  bbrr_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .col          (col),
    .row          (row),
    .red_in       (red_in),
    .green_in     (green_in),
    .blue_in      (blue_in),
    .cfg          (cfg),
    .mul_req      (mul_req),
    .mul_prod     (mul_prod),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .done         (done),
    .red_out      (red_out),
    .green_out    (green_out),
    .blue_out     (blue_out),
    .sample_count (sample_count),
    .window_empty (window_empty)
  );

  bbrr_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (mul_prod)
  );

  bbrr_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire
